/* rtl/core/bpc_pkg.sv */
// shared types and constants for the barometric pressure compensation unit
package bpc_pkg;

   localparam int CsrAddrWidth = 5;

   localparam logic [2:0] RegAc1 = 3'd0;
   localparam logic [2:0] RegAc2 = 3'd1;
   localparam logic [2:0] RegAc3 = 3'd2;
   localparam logic [2:0] RegAc4 = 3'd3;
   localparam logic [2:0] RegAc5 = 3'd4;
   localparam logic [2:0] RegAc6 = 3'd5;
   localparam logic [2:0] RegB1B2 = 3'd6;
   localparam logic [2:0] RegMcMd = 3'd7;

   localparam logic [1:0] StatusOk = 2'd0;
   localparam logic [1:0] StatusRawZero = 2'd1;
   localparam logic [1:0] StatusDivZero = 2'd2;

   localparam logic [31:0] B6Offset = 32'd4000;
   localparam logic [31:0] PC1 = 32'd3038;
   localparam logic [31:0] PC2 = 32'hFFFF_E343; // -7357
   localparam logic [31:0] PC3 = 32'd3791;
   localparam logic [31:0] B7Scale = 32'd50000;
   localparam logic [31:0] HalfRange = 32'd32768;
   localparam logic [31:0] SignBit = 32'h8000_0000;

   // datapath steps, one per cycle except the divider wait
   typedef enum logic [4:0] {
      S_IDLE, S_T0, S_T1, S_T2, S_TDIV, S_TWAIT, S_TFIN,
      S_P0, S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_P7, S_P8, S_P9,
      S_PDIV, S_PWAIT, S_P10, S_P11, S_P12, S_P13, S_P14, S_OUT
   } state_type;

   typedef struct packed {
      state_type step;
      logic      start;
   } cmd_type;

   typedef struct packed {
      logic raw_zero;
      logic div_zero;
      logic div_done;
   } sts_type;

   typedef struct packed {
      logic [15:0] ac1, ac2, ac3, ac4, ac5, ac6;
      logic [31:0] b1_b2, mc_md;
   } coef_type;

endpackage

/* rtl/core/bpc_stream_if.sv */
// valid/ready channel carrying one item
interface bpc_stream_if #(parameter int Width = 25);
   logic             valid;
   logic             ready;
   logic [Width-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

/* rtl/core/bpc_divider.sv */
// restoring 32-bit unsigned divider, one quotient bit per cycle
module bpc_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [31:0] divisor,
   output logic [31:0] quotient,
   output logic        done
);
   logic [31:0] rem_ff, rem_in, quo_ff, quo_in, dsr_ff, dsr_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [33:0] trial;

   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      dsr_in = dsr_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      // shifted remainder can reach 33 bits, so the borrow sits in bit 33
      trial = {1'b0, rem_ff, quo_ff[31]} - {2'b0, dsr_ff};
      if (start) begin
         rem_in = '0;
         quo_in = dividend;
         dsr_in = divisor;
         cnt_in = 6'd32;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial[33]) begin
            rem_in = {rem_ff[30:0], quo_ff[31]};
            quo_in = {quo_ff[30:0], 1'b0};
         end else begin
            rem_in = trial[31:0];
            quo_in = {quo_ff[30:0], 1'b1};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quotient = quo_ff;
   assign done = done_ff;
endmodule

/* rtl/core/bpc_datapath.sv */
// compensation datapath: shared multiplier, shifter, divider and working registers
module bpc_datapath #(
   parameter int Oversampling = 3
) (
   input  logic              clock,
   input  logic              reset,
   input  bpc_pkg::cmd_type  cmd,
   input  bpc_pkg::coef_type coef,
   input  logic              in_load,
   input  logic              in_mode,
   input  logic [23:0]       in_raw,
   output bpc_pkg::sts_type  sts,
   output logic              res_kind,
   output logic [31:0]       res_value,
   output logic [1:0]        res_status
);
   import bpc_pkg::*;

   localparam int Oss = Oversampling;

   logic [31:0] raw_ff, raw_in;
   logic        mode_ff, mode_in;
   logic [31:0] a_ff, a_in, b_ff, b_in, c_ff, c_in, d_ff, d_in, e_ff, e_in;
   logic [31:0] term_ff, term_in;
   logic [31:0] val_ff, val_in;
   logic [1:0]  st_ff, st_in;
   logic [31:0] mul_a, mul_b, prod;
   logic [31:0] div_n, div_d, div_q;
   logic        div_start, div_done;
   logic [31:0] md, mcs, b1, b2, ac1, ac2, ac3;
   logic [63:0] b4_wide;

   // arithmetic right shift kept self-contained inside a sum
   function automatic logic [31:0] sra(input logic [31:0] x, input int n);
      return 32'($signed(x) >>> n);
   endfunction

   assign md  = {{16{coef.mc_md[15]}}, coef.mc_md[15:0]};
   assign mcs = {{16{coef.mc_md[31]}}, coef.mc_md[31:16]};
   assign b1  = {{16{coef.b1_b2[31]}}, coef.b1_b2[31:16]};
   assign b2  = {{16{coef.b1_b2[15]}}, coef.b1_b2[15:0]};
   assign ac1 = {{16{coef.ac1[15]}}, coef.ac1};
   assign ac2 = {{16{coef.ac2[15]}}, coef.ac2};
   assign ac3 = {{16{coef.ac3[15]}}, coef.ac3};

   // shared 32x32 multiplier, low word kept; b4 has its own ac4 product
   assign prod = mul_a * mul_b;
   assign b4_wide = {48'd0, coef.ac4} * {32'd0, a_ff};

   bpc_divider u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .dividend(div_n), .divisor(div_d), .quotient(div_q), .done(div_done)
   );

   always_comb begin
      raw_in = raw_ff;
      mode_in = mode_ff;
      a_in = a_ff; b_in = b_ff; c_in = c_ff; d_in = d_ff; e_in = e_ff;
      term_in = term_ff;
      val_in = val_ff;
      st_in = st_ff;
      mul_a = a_ff;
      mul_b = b_ff;
      div_start = 1'b0;
      div_n = a_ff;
      div_d = b_ff;
      if (in_load) begin
         mode_in = in_mode;
         raw_in = in_mode ? ({8'd0, in_raw} >> (8 - Oss)) : {16'd0, in_raw[15:0]};
         val_in = '0;
         st_in = StatusOk;
      end
      case (cmd.step)
         S_T0: begin
            mul_a = raw_ff - {16'd0, coef.ac6};
            mul_b = {16'd0, coef.ac5};
            a_in = $signed(prod) >>> 15;              // x1
         end
         S_T1: begin
            b_in = a_ff + md;                          // den
            c_in = mcs << 11;                          // num
         end
         S_T2: begin
            d_in = c_ff[31] ? -c_ff : c_ff;
            e_in = b_ff[31] ? -b_ff : b_ff;
         end
         S_TDIV: begin
            div_start = 1'b1;
            div_n = d_ff;
            div_d = e_ff;
         end
         S_TFIN: begin
            e_in = a_ff + ((c_ff[31] ^ b_ff[31]) ? -div_q : div_q);
         end
         S_P0: begin
            a_in = term_ff - B6Offset;                 // b6
         end
         S_P1: begin
            mul_a = a_ff; mul_b = a_ff;
            b_in = $signed(prod) >>> 12;               // sq
         end
         S_P2: begin
            mul_a = b2; mul_b = b_ff;
            c_in = $signed(prod) >>> 11;
         end
         S_P3: begin
            mul_a = ac2; mul_b = a_ff;
            c_in = c_ff + sra(prod, 11);               // x3
         end
         S_P4: begin
            d_in = $signed((((ac1 << 2) + c_ff) << Oss) + 32'd2) >>> 2; // b3
         end
         S_P5: begin
            mul_a = ac3; mul_b = a_ff;
            c_in = $signed(prod) >>> 13;
         end
         S_P6: begin
            mul_a = b1; mul_b = b_ff;
            c_in = sra(c_ff + sra(prod, 16) + 32'd2, 2);
         end
         S_P7: begin
            a_in = c_ff + HalfRange;
         end
         S_P8: begin
            b_in = b4_wide[46:15];                     // b4
         end
         S_P9: begin
            mul_a = raw_ff - d_ff; mul_b = B7Scale >> Oss;
            e_in = prod;                               // b7
         end
         S_PDIV: begin
            div_start = 1'b1;
            div_n = (e_ff < SignBit) ? (e_ff << 1) : e_ff;
            div_d = b_ff;
         end
         S_P10: begin
            c_in = (e_ff < SignBit) ? div_q : (div_q << 1); // p
         end
         S_P11: begin
            mul_a = $signed(c_ff) >>> 8; mul_b = $signed(c_ff) >>> 8;
            d_in = prod;
         end
         S_P12: begin
            mul_a = d_ff; mul_b = PC1;
            d_in = $signed(prod) >>> 16;
         end
         S_P13: begin
            mul_a = PC2; mul_b = c_ff;
            d_in = d_ff + sra(prod, 16);
         end
         S_P14: begin
            e_in = c_ff + sra(d_ff + PC3, 4);
         end
         S_OUT: begin
            if (sts.raw_zero) begin
               st_in = StatusRawZero;
               val_in = '0;
            end else if (sts.div_zero) begin
               st_in = StatusDivZero;
               val_in = '0;
            end else if (!mode_ff) begin
               term_in = e_ff;
               val_in = $signed(e_ff + 32'd8) >>> 4;
            end else begin
               val_in = e_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      raw_ff <= raw_in; mode_ff <= mode_in;
      a_ff <= a_in; b_ff <= b_in; c_ff <= c_in; d_ff <= d_in; e_ff <= e_in;
      val_ff <= val_in; st_ff <= st_in;
      if (reset) term_ff <= '0;
      else term_ff <= term_in;
   end

   assign sts.raw_zero = (raw_ff == 32'd0);
   assign sts.div_zero = (b_ff == 32'd0);
   assign sts.div_done = div_done;
   assign res_kind = mode_ff;
   assign res_value = val_ff;
   assign res_status = st_ff;
endmodule

/* rtl/core/bpc_controller.sv */
// sequencer stepping the datapath through one item
module bpc_controller (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             mode,
   input  bpc_pkg::sts_type sts,
   output bpc_pkg::cmd_type cmd,
   output logic             idle,
   output logic             finish
);
   import bpc_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      finish = 1'b0;
      case (state_ff)
         S_IDLE:  if (start) state_in = mode ? S_P0 : S_T0;
         S_T0:    state_in = sts.raw_zero ? S_OUT : S_T1;
         S_T1:    state_in = S_T2;
         S_T2:    state_in = sts.div_zero ? S_OUT : S_TDIV;
         S_TDIV:  state_in = S_TWAIT;
         S_TWAIT: if (sts.div_done) state_in = S_TFIN;
         S_TFIN:  state_in = S_OUT;
         S_P0:    state_in = sts.raw_zero ? S_OUT : S_P1;
         S_P1:    state_in = S_P2;
         S_P2:    state_in = S_P3;
         S_P3:    state_in = S_P4;
         S_P4:    state_in = S_P5;
         S_P5:    state_in = S_P6;
         S_P6:    state_in = S_P7;
         S_P7:    state_in = S_P8;
         S_P8:    state_in = S_P9;
         S_P9:    state_in = sts.div_zero ? S_OUT : S_PDIV;
         S_PDIV:  state_in = S_PWAIT;
         S_PWAIT: if (sts.div_done) state_in = S_P10;
         S_P10:   state_in = S_P11;
         S_P11:   state_in = S_P12;
         S_P12:   state_in = S_P13;
         S_P13:   state_in = S_P14;
         S_P14:   state_in = S_OUT;
         S_OUT: begin
            finish = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign cmd.step = state_ff;
   assign cmd.start = start;
   assign idle = (state_ff == S_IDLE);
endmodule

/* rtl/core/barometric_pressure_compensation_unit.sv */
// top level of the barometric pressure compensation unit
// Compensates raw barometric sensor readings with calibration coefficients held
// in eight csr registers. A mode 0 item is a raw temperature reading: the unit
// keeps the intermediate term and returns temperature in 0.1 degree steps. A mode
// 1 item is a raw pressure reading shifted by 8 minus the oversampling setting:
// it uses the kept term and returns pressure in pascals. One item is worked at a
// time, stepping through the shared multiplier and the bit-serial divider. The
// result sits in an output register, and the next item is accepted only once
// that result has been taken.
module barometric_pressure_compensation_unit #(
   parameter int Oversampling = 3
) (
   input  logic                              clock,
   input  logic                              reset,
   bpc_stream_if.sink                        req,
   bpc_stream_if.source                      rsp,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [bpc_pkg::CsrAddrWidth-1:0]  csr_paddr,
   input  logic [31:0]                       csr_pwdata,
   output logic [31:0]                       csr_prdata,
   output logic                              csr_pready
);
   import bpc_pkg::*;

   coef_type coef_ff, coef_in;
   cmd_type  cmd;
   sts_type  sts;
   logic     idle, finish, accept;
   logic     rsp_valid_ff, rsp_valid_in;
   logic     finish_d_ff;
   logic     out_kind_ff;
   logic [31:0] out_value_ff;
   logic [1:0]  out_status_ff;
   logic        dp_kind;
   logic [31:0] dp_value;
   logic [1:0]  dp_status;
   logic [2:0]  reg_idx;
   logic        wr;

   // csr register file
   assign csr_pready = 1'b1;
   assign reg_idx = csr_paddr[4:2];
   assign wr = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      coef_in = coef_ff;
      if (wr && csr_paddr[1:0] == 2'd0) begin
         case (reg_idx)
            RegAc1:  coef_in.ac1 = csr_pwdata[15:0];
            RegAc2:  coef_in.ac2 = csr_pwdata[15:0];
            RegAc3:  coef_in.ac3 = csr_pwdata[15:0];
            RegAc4:  coef_in.ac4 = csr_pwdata[15:0];
            RegAc5:  coef_in.ac5 = csr_pwdata[15:0];
            RegAc6:  coef_in.ac6 = csr_pwdata[15:0];
            RegB1B2: coef_in.b1_b2 = csr_pwdata;
            RegMcMd: coef_in.mc_md = csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         RegAc1:  csr_prdata = {16'd0, coef_ff.ac1};
         RegAc2:  csr_prdata = {16'd0, coef_ff.ac2};
         RegAc3:  csr_prdata = {16'd0, coef_ff.ac3};
         RegAc4:  csr_prdata = {16'd0, coef_ff.ac4};
         RegAc5:  csr_prdata = {16'd0, coef_ff.ac5};
         RegAc6:  csr_prdata = {16'd0, coef_ff.ac6};
         RegB1B2: csr_prdata = coef_ff.b1_b2;
         RegMcMd: csr_prdata = coef_ff.mc_md;
         default: csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff.ac1 <= 16'd408;
         coef_ff.ac2 <= 16'hFFB8;
         coef_ff.ac3 <= 16'hC7D1;
         coef_ff.ac4 <= 16'd32741;
         coef_ff.ac5 <= 16'd32757;
         coef_ff.ac6 <= 16'd23153;
         coef_ff.b1_b2 <= 32'd405667844;
         coef_ff.mc_md <= 32'd3724086068;
      end else begin
         coef_ff <= coef_in;
      end
   end

   // take an item only when the sequencer is idle and no result is pending
   assign req.ready = idle && !finish_d_ff && !rsp_valid_ff;
   assign accept = req.valid && req.ready;

   bpc_controller u_ctrl (
      .clock(clock), .reset(reset), .start(accept), .mode(req.data[24]),
      .sts(sts), .cmd(cmd), .idle(idle), .finish(finish)
   );

   bpc_datapath #(.Oversampling(Oversampling)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .coef(coef_ff),
      .in_load(accept), .in_mode(req.data[24]), .in_raw(req.data[23:0]),
      .sts(sts), .res_kind(dp_kind), .res_value(dp_value), .res_status(dp_status)
   );

   // output register; datapath result is valid in the cycle after the out step
   always_ff @(posedge clock) begin
      if (reset) finish_d_ff <= 1'b0;
      else finish_d_ff <= finish;
   end

   // result waits here until taken; no new item starts meanwhile
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp.ready) rsp_valid_in = 1'b0;
      if (finish_d_ff) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else rsp_valid_ff <= rsp_valid_in;
      if (finish_d_ff) begin
         out_kind_ff <= dp_kind;
         out_value_ff <= dp_value;
         out_status_ff <= dp_status;
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.data = {out_kind_ff, out_value_ff, out_status_ff};
endmodule

/* test/tb_barometric_pressure_compensation_unit.sv */
// testbench for the barometric pressure compensation unit
`timescale 1ns / 1ps

module tb_barometric_pressure_compensation_unit;
   import bpc_pkg::*;

   localparam int Oss = 3;
   localparam int HoldCycles = 400;
   localparam int StallLimit = 5000;

   typedef struct packed {
      logic        kind;
      logic [31:0] value;
      logic [1:0]  status;
   } reading_type;

   // golden compensation math plus the queue of readings still owed by the block
   class compensation_board;
      logic [15:0] ac1, ac2, ac3, ac4, ac5, ac6;
      logic [31:0] b1_b2, mc_md, temp_term;
      reading_type owed[$];
      int errors;

      function new();
         ac1 = 16'd408; ac2 = 16'hFFB8; ac3 = 16'hC7D1;
         ac4 = 16'd32741; ac5 = 16'd32757; ac6 = 16'd23153;
         b1_b2 = 32'd405667844; mc_md = 32'd3724086068;
         temp_term = '0;
         errors = 0;
      endfunction

      function logic [31:0] sx(logic [15:0] v);
         return {{16{v[15]}}, v};
      endfunction

      function logic [31:0] sar(logic [31:0] x, int n);
         return $signed(x) >>> n;
      endfunction

      function void set_reg(logic [2:0] idx, logic [31:0] v);
         case (idx)
            RegAc1: ac1 = v[15:0];
            RegAc2: ac2 = v[15:0];
            RegAc3: ac3 = v[15:0];
            RegAc4: ac4 = v[15:0];
            RegAc5: ac5 = v[15:0];
            RegAc6: ac6 = v[15:0];
            RegB1B2: b1_b2 = v;
            default: mc_md = v;
         endcase
      endfunction

      function void note_item(logic mode, logic [23:0] raw);
         logic [31:0] ut, up, x1, x2, x3, den, num, b5, b6, sq, b3, b4, b7, p, prod;
         logic [63:0] wide;
         int q;
         reading_type r;
         r.kind = mode;
         r.value = '0;
         r.status = StatusOk;
         if (!mode) begin
            ut = {16'b0, raw[15:0]};
            if (ut == 0) r.status = StatusRawZero;
            else begin
               prod = (ut - {16'b0, ac6}) * {16'b0, ac5};
               x1 = sar(prod, 15);
               den = x1 + sx(mc_md[15:0]);
               if (den == 0) r.status = StatusDivZero;
               else begin
                  num = sx(mc_md[31:16]) << 11;
                  q = $signed(num) / $signed(den);
                  b5 = x1 + q;
                  temp_term = b5;
                  r.value = sar(b5 + 32'd8, 4);
               end
            end
         end else begin
            up = {8'b0, raw} >> (8 - Oss);
            if (up == 0) r.status = StatusRawZero;
            else begin
               b6 = temp_term - B6Offset;
               prod = b6 * b6;
               sq = sar(prod, 12);
               prod = sx(b1_b2[15:0]) * sq;
               x1 = sar(prod, 11);
               prod = sx(ac2) * b6;
               x2 = sar(prod, 11);
               x3 = x1 + x2;
               prod = ((sx(ac1) * 32'd4 + x3) << Oss) + 32'd2;
               b3 = sar(prod, 2);
               prod = sx(ac3) * b6;
               x1 = sar(prod, 13);
               prod = sx(b1_b2[31:16]) * sq;
               x2 = sar(prod, 16);
               x3 = sar(x1 + x2 + 32'd2, 2);
               wide = {48'b0, ac4} * {32'b0, x3 + HalfRange};
               b4 = wide[46:15];
               if (b4 == 0) r.status = StatusDivZero;
               else begin
                  b7 = (up - b3) * (B7Scale >> Oss);
                  if (b7 < SignBit) p = (b7 << 1) / b4;
                  else p = (b7 / b4) << 1;
                  prod = sar(p, 8) * sar(p, 8);
                  prod = prod * PC1;
                  x1 = sar(prod, 16);
                  prod = PC2 * p;
                  x2 = sar(prod, 16);
                  r.value = p + sar(x1 + x2 + PC3, 4);
               end
            end
         end
         owed.push_back(r);
      endfunction

      function void check(reading_type got);
         reading_type want;
         if (owed.size() == 0) begin
            $display("%0t: unexpected result kind %0d value %0d status %0d", $time,
                     got.kind, $signed(got.value), got.status);
            errors++;
            return;
         end
         want = owed.pop_front();
         if (got.kind !== want.kind) begin
            $display("%0t: kind expected %0d actual %0d", $time, want.kind, got.kind);
            errors++;
         end
         if (got.value !== want.value) begin
            $display("%0t: value expected %0d actual %0d", $time,
                     $signed(want.value), $signed(got.value));
            errors++;
         end
         if (got.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
            errors++;
         end
      endfunction
   endclass

   logic clock, reset;
   logic csr_psel, csr_penable, csr_pwrite;
   logic [CsrAddrWidth-1:0] csr_paddr;
   logic [31:0] csr_pwdata, csr_prdata;
   logic csr_pready;

   bpc_stream_if #(.Width(25)) req ();
   bpc_stream_if #(.Width(35)) rsp ();

   barometric_pressure_compensation_unit #(.Oversampling(Oss)) DUT (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   compensation_board board = new();

   logic [24:0] stim[$];     // {mode, raw} items of the current phase
   int sent;                 // items of stim accepted so far
   int idle_pct = 35;        // percent of cycles each side idles
   int hold_left = 0;        // receiver hold-off cycles still to go
   int quiet = 0;            // cycles with no accepted item on either side

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   // sender: one nonblocking write per edge, a new item only after the last was taken
   initial begin
      req.valid = 0;
      req.data = '0;
      sent = 0;
      forever begin
         @(posedge clock);
         if (!reset) begin
            if (req.valid && req.ready) begin
               board.note_item(req.data[24], req.data[23:0]);
               sent++;
            end
            if (!req.valid || req.ready) begin
               if (sent < stim.size() && $urandom_range(99) >= idle_pct) begin
                  req.valid <= 1'b1;
                  req.data <= stim[sent];
               end else req.valid <= 1'b0;
            end
         end
      end
   end

   // receiver with random stalls and the long hold-off
   initial begin
      rsp.ready = 0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp.ready <= 1'b0;
         end else rsp.ready <= ($urandom_range(99) >= idle_pct);
      end
   end

   // result check
   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready) board.check(rsp.data);
   end

   // watchdog on cycles without progress
   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= StallLimit) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // setup and access cycle of one register write
   task automatic csr_write(logic [2:0] idx, logic [31:0] v);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CsrAddrWidth'(idx) << 2;
      csr_pwdata <= v;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      board.set_reg(idx, v);
   endtask

   task automatic write_all(logic [31:0] v[8]);
      for (int i = 0; i < 8; i++) csr_write(3'(i), v[i]);
   endtask

   // mostly temperature/pressure pairs with plausible readings, the rest anything
   task automatic add_random(int n);
      logic [23:0] raw;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(9) < 7) begin
            raw = 24'($urandom);
            if (i % 2 == 0) stim.push_back({1'b0, 8'(raw[23:16]), 16'($urandom_range(35000, 20000))});
            else stim.push_back({1'b1, 24'($urandom_range(24'h600000, 24'h300000))});
         end else begin
            raw = 24'($urandom);
            stim.push_back({1'($urandom_range(1)), raw});
         end
      end
   endtask

   // feed the queued items and wait until every result is back
   task automatic run_stim();
      sent = 0;
      wait (sent == stim.size() && board.owed.size() == 0);
      repeat (80) @(posedge clock);
      stim.delete();
      sent = 0;
   endtask

   logic [31:0] regs[8];

   initial begin
      reset = 1;
      csr_psel = 0; csr_penable = 0; csr_pwrite = 0;
      csr_paddr = '0; csr_pwdata = '0;
      repeat (9) @(posedge clock);
      reset <= 0;

      // directed items at reset coefficients, pressure before any temperature first
      stim.push_back({1'b1, 24'h5D2340});
      stim.push_back({1'b1, 24'h00001F});   // shifts to zero
      stim.push_back({1'b1, 24'h000020});
      stim.push_back({1'b0, 24'h000000});   // raw temperature zero
      stim.push_back({1'b0, 24'hFF0000});   // high bits ignored, still zero
      stim.push_back({1'b0, 24'h006C50});
      stim.push_back({1'b1, 24'h5D2340});
      stim.push_back({1'b1, 24'hFFFFFF});
      stim.push_back({1'b0, 24'h00FFFF});
      stim.push_back({1'b1, 24'hFFFFFF});
      stim.push_back({1'b0, 24'h000001});
      stim.push_back({1'b1, 24'h000100});
      stim.push_back({1'b0, 24'hFFFFFF});
      stim.push_back({1'b1, 24'h800000});
      run_stim();

      // reset values, with a long stretch of no idling
      idle_pct = 0;
      add_random(200);
      run_stim();
      idle_pct = 35;

      // random coefficients, receiver holds off so the block backs up
      for (int i = 0; i < 8; i++) regs[i] = $urandom;
      write_all(regs);
      add_random(200);
      fork
         run_stim();
         begin
            repeat (30) @(posedge clock);
            hold_left = HoldCycles;
         end
      join

      // all zero: both divisors become zero
      for (int i = 0; i < 8; i++) regs[i] = '0;
      write_all(regs);
      add_random(100);
      run_stim();

      // all ones
      for (int i = 0; i < 8; i++) regs[i] = 32'hFFFFFFFF;
      write_all(regs);
      add_random(150);
      run_stim();

      // md cancels x1 for ut equal to ac6, ac4 at its top
      regs = '{32'h00007FFF, 32'h00008000, 32'h00007FFF, 32'h0000FFFF,
               32'h0000FFFF, 32'h00005A71, 32'h80007FFF, 32'h7FFF0000};
      write_all(regs);
      stim.push_back({1'b0, 24'h005A71});
      add_random(150);
      run_stim();

      // typical values again, then more random sets
      regs = '{32'd408, 32'hFFB8, 32'hC7D1, 32'd32741, 32'd32757, 32'd23153,
               32'd405667844, 32'd3724086068};
      write_all(regs);
      add_random(200);
      run_stim();

      for (int i = 0; i < 8; i++) regs[i] = $urandom;
      write_all(regs);
      add_random(200);
      run_stim();

      if (board.errors == 0 && board.owed.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/core/bpc_pkg.sv
rtl/core/bpc_stream_if.sv
rtl/core/bpc_divider.sv
rtl/core/bpc_datapath.sv
rtl/core/bpc_controller.sv
rtl/core/barometric_pressure_compensation_unit.sv
test/tb_barometric_pressure_compensation_unit.sv
